// File: rtl/gvn_pkg.sv
`timescale 1ns / 1ps
package gvn_pkg;

  localparam int COORD_BITS      = 10;
  localparam int MAX_CELLS       = 256;
  localparam int PTS_PER_CELL    = 4;
  localparam int CELL_BITS       = $clog2(MAX_CELLS);
  localparam int SLOT_BITS       = $clog2(PTS_PER_CELL);
  localparam int CNT_BITS        = $clog2(PTS_PER_CELL + 1);
  localparam int ADDR_BITS       = CELL_BITS + SLOT_BITS;
  localparam int LABEL_BITS      = 16;
  localparam int DIST_BITS       = 17;
  localparam int SQ_BITS         = 2 * COORD_BITS + 1;
  localparam int MSIZE_BITS      = 7;
  localparam int MCNT_BITS       = 5;
  localparam int GRID_BITS       = 4;
  localparam int DIV_CNT_BITS    = $clog2(COORD_BITS + 1);

  localparam logic [MSIZE_BITS-1:0] MSIZE_MAX = MSIZE_BITS'(64);
  localparam logic [MCNT_BITS-1:0]  MCNT_MAX  = MCNT_BITS'(16);
  localparam logic [DIST_BITS-1:0]  DIST_SAT  = {DIST_BITS{1'b1}};

  typedef enum logic [1:0] {
    KIND_CLEAR = 2'd0,
    KIND_LOAD  = 2'd1,
    KIND_QUERY = 2'd2,
    KIND_NONE  = 2'd3
  } kind_t;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_FULL    = 2'd1,
    ST_OUTSIDE = 2'd2
  } status_t;

  typedef enum logic [2:0] {
    REG_MWIDTH  = 3'd0,
    REG_MHEIGHT = 3'd1,
    REG_MCOLS   = 3'd2,
    REG_MROWS   = 3'd3
  } reg_idx_t;

  typedef struct packed {
    logic [COORD_BITS-1:0] x;
    logic [COORD_BITS-1:0] y;
    logic [LABEL_BITS-1:0] label;
  } point_t;

  typedef struct packed {
    logic                 clr;
    logic                 cnt_rd;
    logic                 cnt_we;
    logic [CELL_BITS-1:0] cnt_addr;
    logic [CNT_BITS-1:0]  cnt_wdata;
    logic                 pt_rd;
    logic                 pt_we;
    logic [ADDR_BITS-1:0] pt_addr;
    point_t               pt_wdata;
  } store_req_t;

endpackage

// File: rtl/gvn_div.sv
`timescale 1ns / 1ps
module gvn_div
  import gvn_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  start,
  input  logic [COORD_BITS-1:0] dividend,
  input  logic [MSIZE_BITS-1:0] divisor,
  output logic                  done,
  output logic [COORD_BITS-1:0] quotient
);

  logic [COORD_BITS-1:0]   dvd_r;
  logic [MSIZE_BITS-1:0]   dvs_r;
  logic [MSIZE_BITS-1:0]   rem_r;
  logic [DIV_CNT_BITS-1:0] cnt_r;
  logic                    busy_r;
  logic                    done_r;
  logic [MSIZE_BITS:0]     trial;
  logic                    ge;

  assign trial    = {rem_r, dvd_r[COORD_BITS-1]};
  assign ge       = trial >= {1'b0, dvs_r};
  assign done     = done_r;
  assign quotient = dvd_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
        dvd_r  <= dividend;
        dvs_r  <= divisor;
        rem_r  <= '0;
      end else if (busy_r) begin
        rem_r <= ge ? MSIZE_BITS'(trial - {1'b0, dvs_r}) : trial[MSIZE_BITS-1:0];
        dvd_r <= {dvd_r[COORD_BITS-2:0], ge};
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == DIV_CNT_BITS'(COORD_BITS - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

endmodule

// File: rtl/gvn_store.sv
`timescale 1ns / 1ps
module gvn_store
  import gvn_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  input  store_req_t          req,
  output logic [CNT_BITS-1:0] cnt_q,
  output point_t              pt_q
);

  point_t              pt_mem  [MAX_CELLS*PTS_PER_CELL];
  logic [CNT_BITS-1:0] cnt_mem [MAX_CELLS];
  logic [MAX_CELLS-1:0] vld_r;
  logic                vld_q_r;
  logic [CNT_BITS-1:0] cnt_q_r;
  point_t              pt_q_r;

  assign cnt_q = vld_q_r ? cnt_q_r : '0;
  assign pt_q  = pt_q_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (req.clr) begin
      vld_r <= '0;
    end else if (req.cnt_we) begin
      vld_r[req.cnt_addr] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (req.cnt_we) begin
      cnt_mem[req.cnt_addr] <= req.cnt_wdata;
    end
    if (req.cnt_rd) begin
      cnt_q_r <= cnt_mem[req.cnt_addr];
      vld_q_r <= vld_r[req.cnt_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (req.pt_we) begin
      pt_mem[req.pt_addr] <= req.pt_wdata;
    end
    if (req.pt_rd) begin
      pt_q_r <= pt_mem[req.pt_addr];
    end
  end

endmodule

// File: rtl/grid_voronoi_nearest_label_top.sv
`timescale 1ns / 1ps
// channel | dir | signals                      | payload
// in      | in  | in_tvalid/in_tready          | tdata: pos_x, pos_y, point_label; tuser: kind
// out     | out | out_tvalid/out_tready        | tdata: nearest_label, found, dist; tuser: status
// cfg     | in  | cfg_we/cfg_index/cfg_wdata   | register write, no handshake
// One item at a time. Two serial divides (one shared divider) find the macro
// cell; a query then walks up to 9 cells, reading the count of each in-grid
// cell and then each stored point (one shared squarer); cells off the grid are skipped.
// Clear and kind 3 go straight to S_DONE. Reset: synchronous rst_n, all cells
// empty. A result waits in the output register; the next item is taken meanwhile
// and its result stalls in S_DONE.
module grid_voronoi_nearest_label_top
  import gvn_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [39:0]           in_tdata,   // pos_x, pos_y, point_label, zero pad
  input  logic [1:0]            in_tuser,   // kind
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [39:0]           out_tdata,  // nearest_label, found, nearest_distance, pad
  output logic [1:0]            out_tuser,  // status
  input  logic                  cfg_we,
  input  logic [2:0]            cfg_index,
  input  logic [MSIZE_BITS-1:0] cfg_wdata
);

  typedef enum logic [3:0] {
    S_IDLE, S_DIVX, S_DIVY, S_CHK, S_LRD, S_LWAIT,
    S_QCELL, S_QCNT, S_QRD, S_QDX, S_QDY, S_DONE
  } state_t;

  state_t                state_r, state_nxt;
  logic [MSIZE_BITS-1:0] mw_r, mh_r;
  logic [MCNT_BITS-1:0]  mc_r, mr_r;
  logic [MSIZE_BITS-1:0] mw_e, mh_e;
  logic [MCNT_BITS-1:0]  mc_e, mr_e;

  kind_t                 kind_r, kind_nxt;
  logic [COORD_BITS-1:0] px_r, px_nxt, py_r, py_nxt, cx_r, cx_nxt, cy_r, cy_nxt;
  logic [LABEL_BITS-1:0] lab_r, lab_nxt;
  logic [CELL_BITS-1:0]  cell_r, cell_nxt, nc_r, nc_nxt;
  logic [1:0]            nbx_r, nbx_nxt, nby_r, nby_nxt;
  logic [CNT_BITS-1:0]   cnt_r, cnt_nxt, k_r, k_nxt;
  logic [SQ_BITS-1:0]    sq_r, sq_nxt, best_r, best_nxt;
  logic                  hit_r, hit_nxt;
  logic [LABEL_BITS-1:0] blab_r, blab_nxt;
  status_t               stat_r, stat_nxt;
  logic                  ov_r, ov_nxt;
  logic [39:0]           od_r, od_nxt;
  logic [1:0]            ou_r, ou_nxt;

  logic                  div_start, div_done;
  logic [COORD_BITS-1:0] div_dvd, div_q;
  logic [MSIZE_BITS-1:0] div_dvs;
  store_req_t            req;
  logic [CNT_BITS-1:0]   cnt_q;
  point_t                pt_q;

  logic [MCNT_BITS-1:0]  ny, nx;
  logic                  nb_ok;
  logic [COORD_BITS-1:0] dx, dy, mul_a;
  logic [SQ_BITS-1:0]    mul_p, dsum;
  logic [2*MCNT_BITS-1:0] cell_w, nc_w;
  logic                  nb_last;

  assign mw_e = (mw_r == '0) ? MSIZE_BITS'(1) : ((mw_r > MSIZE_MAX) ? MSIZE_MAX : mw_r);
  assign mh_e = (mh_r == '0) ? MSIZE_BITS'(1) : ((mh_r > MSIZE_MAX) ? MSIZE_MAX : mh_r);
  assign mc_e = (mc_r == '0) ? MCNT_BITS'(1) : ((mc_r > MCNT_MAX) ? MCNT_MAX : mc_r);
  assign mr_e = (mr_r == '0) ? MCNT_BITS'(1) : ((mr_r > MCNT_MAX) ? MCNT_MAX : mr_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mw_r <= MSIZE_BITS'(8);
      mh_r <= MSIZE_BITS'(8);
      mc_r <= MCNT_BITS'(16);
      mr_r <= MCNT_BITS'(16);
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_MWIDTH:  mw_r <= cfg_wdata;
        REG_MHEIGHT: mh_r <= cfg_wdata;
        REG_MCOLS:   mc_r <= cfg_wdata[MCNT_BITS-1:0];
        REG_MROWS:   mr_r <= cfg_wdata[MCNT_BITS-1:0];
        default: ;
      endcase
    end
  end

  gvn_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_dvd),
    .divisor  (div_dvs),
    .done     (div_done),
    .quotient (div_q)
  );

  gvn_store u_store (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (req),
    .cnt_q (cnt_q),
    .pt_q  (pt_q)
  );

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = ov_r;
  assign out_tdata  = od_r;
  assign out_tuser  = ou_r;

  assign cell_w = (2*MCNT_BITS)'(cy_r[GRID_BITS-1:0]) * (2*MCNT_BITS)'(mc_e)
                + (2*MCNT_BITS)'(cx_r[GRID_BITS-1:0]);
  assign ny     = MCNT_BITS'(cy_r[GRID_BITS-1:0]) + MCNT_BITS'(nby_r) - MCNT_BITS'(1);
  assign nx     = MCNT_BITS'(cx_r[GRID_BITS-1:0]) + MCNT_BITS'(nbx_r) - MCNT_BITS'(1);
  assign nb_ok  = !ny[MCNT_BITS-1] && !nx[MCNT_BITS-1] && (ny < mr_e) && (nx < mc_e);
  assign nc_w   = (2*MCNT_BITS)'(ny[GRID_BITS-1:0]) * (2*MCNT_BITS)'(mc_e)
                + (2*MCNT_BITS)'(nx[GRID_BITS-1:0]);
  assign nb_last = (nbx_r == 2'd2) && (nby_r == 2'd2);

  assign dx    = (pt_q.x > px_r) ? pt_q.x - px_r : px_r - pt_q.x;
  assign dy    = (pt_q.y > py_r) ? pt_q.y - py_r : py_r - pt_q.y;
  assign mul_a = (state_r == S_QDX) ? dx : dy;
  assign mul_p = SQ_BITS'(mul_a) * SQ_BITS'(mul_a);
  assign dsum  = sq_r + mul_p;

  always_comb begin
    state_nxt = state_r;
    kind_nxt  = kind_r;
    px_nxt    = px_r;
    py_nxt    = py_r;
    lab_nxt   = lab_r;
    cx_nxt    = cx_r;
    cy_nxt    = cy_r;
    cell_nxt  = cell_r;
    nc_nxt    = nc_r;
    nbx_nxt   = nbx_r;
    nby_nxt   = nby_r;
    cnt_nxt   = cnt_r;
    k_nxt     = k_r;
    sq_nxt    = sq_r;
    best_nxt  = best_r;
    hit_nxt   = hit_r;
    blab_nxt  = blab_r;
    stat_nxt  = stat_r;
    ov_nxt    = ov_r && !out_tready;
    od_nxt    = od_r;
    ou_nxt    = ou_r;
    div_start = 1'b0;
    div_dvd   = px_r;
    div_dvs   = mw_e;
    req       = '0;
    req.cnt_addr  = cell_r;
    req.pt_addr   = {cell_r, cnt_q[SLOT_BITS-1:0]};
    req.pt_wdata  = '{x: px_r, y: py_r, label: lab_r};
    req.cnt_wdata = cnt_q + 1'b1;

    unique case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          kind_nxt = kind_t'(in_tuser);
          px_nxt   = in_tdata[9:0];
          py_nxt   = in_tdata[19:10];
          lab_nxt  = in_tdata[35:20];
          hit_nxt  = 1'b0;
          best_nxt = '0;
          blab_nxt = '0;
          stat_nxt = ST_OK;
          nbx_nxt  = '0;
          nby_nxt  = '0;
          case (kind_t'(in_tuser))
            KIND_LOAD, KIND_QUERY: begin
              div_start = 1'b1;
              div_dvd   = in_tdata[9:0];
              state_nxt = S_DIVX;
            end
            KIND_CLEAR: begin
              req.clr   = 1'b1;
              state_nxt = S_DONE;
            end
            default: state_nxt = S_DONE;
          endcase
        end
      end
      S_DIVX: begin
        if (div_done) begin
          cx_nxt    = div_q;
          div_start = 1'b1;
          div_dvd   = py_r;
          div_dvs   = mh_e;
          state_nxt = S_DIVY;
        end
      end
      S_DIVY: begin
        if (div_done) begin
          cy_nxt    = div_q;
          state_nxt = S_CHK;
        end
      end
      S_CHK: begin
        cell_nxt = cell_w[CELL_BITS-1:0];
        if (cx_r >= COORD_BITS'(mc_e) || cy_r >= COORD_BITS'(mr_e)) begin
          stat_nxt  = ST_OUTSIDE;
          state_nxt = S_DONE;
        end else if (kind_r == KIND_LOAD) begin
          state_nxt = S_LRD;
        end else begin
          state_nxt = S_QCELL;
        end
      end
      S_LRD: begin
        req.cnt_rd = 1'b1;
        state_nxt  = S_LWAIT;
      end
      S_LWAIT: begin
        if (cnt_q >= CNT_BITS'(PTS_PER_CELL)) begin
          stat_nxt = ST_FULL;
        end else begin
          req.pt_we  = 1'b1;
          req.cnt_we = 1'b1;
        end
        state_nxt = S_DONE;
      end
      S_QCELL: begin
        if (nb_ok) begin
          req.cnt_rd   = 1'b1;
          req.cnt_addr = nc_w[CELL_BITS-1:0];
          nc_nxt       = nc_w[CELL_BITS-1:0];
          state_nxt    = S_QCNT;
        end else if (nb_last) begin
          state_nxt = S_DONE;
        end else begin
          nbx_nxt = (nbx_r == 2'd2) ? 2'd0 : nbx_r + 2'd1;
          nby_nxt = (nbx_r == 2'd2) ? nby_r + 2'd1 : nby_r;
        end
      end
      S_QCNT: begin
        cnt_nxt   = cnt_q;
        k_nxt     = '0;
        state_nxt = S_QRD;
      end
      S_QRD: begin
        if (k_r < cnt_r) begin
          req.pt_rd   = 1'b1;
          req.pt_addr = {nc_r, k_r[SLOT_BITS-1:0]};
          state_nxt   = S_QDX;
        end else if (nb_last) begin
          state_nxt = S_DONE;
        end else begin
          nbx_nxt   = (nbx_r == 2'd2) ? 2'd0 : nbx_r + 2'd1;
          nby_nxt   = (nbx_r == 2'd2) ? nby_r + 2'd1 : nby_r;
          state_nxt = S_QCELL;
        end
      end
      S_QDX: begin
        sq_nxt    = mul_p;
        state_nxt = S_QDY;
      end
      S_QDY: begin
        if (!hit_r || dsum < best_r) begin
          hit_nxt  = 1'b1;
          best_nxt = dsum;
          blab_nxt = pt_q.label;
        end
        k_nxt     = k_r + 1'b1;
        state_nxt = S_QRD;
      end
      S_DONE: begin
        if (!ov_r || out_tready) begin
          ov_nxt = 1'b1;
          od_nxt = {6'd0,
                    (best_r > SQ_BITS'(DIST_SAT)) ? DIST_SAT : best_r[DIST_BITS-1:0],
                    hit_r, blab_r};
          ou_nxt = stat_r;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      ov_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      ov_r    <= ov_nxt;
    end
    kind_r <= kind_nxt;
    px_r   <= px_nxt;
    py_r   <= py_nxt;
    lab_r  <= lab_nxt;
    cx_r   <= cx_nxt;
    cy_r   <= cy_nxt;
    cell_r <= cell_nxt;
    nc_r   <= nc_nxt;
    nbx_r  <= nbx_nxt;
    nby_r  <= nby_nxt;
    cnt_r  <= cnt_nxt;
    k_r    <= k_nxt;
    sq_r   <= sq_nxt;
    best_r <= best_nxt;
    hit_r  <= hit_nxt;
    blab_r <= blab_nxt;
    stat_r <= stat_nxt;
    od_r   <= od_nxt;
    ou_r   <= ou_nxt;
  end

endmodule
